// ===== hw/rtl/utf8_pkg.sv =====
// Shared types and constants of the UTF-8 decoder and validator.
`timescale 1ns / 1ps

package utf8_pkg;

  // Status codes carried with each result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD       = 3'd1;
  localparam logic [2:0] ST_OVERLONG  = 3'd2;
  localparam logic [2:0] ST_SURROGATE = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // Lead byte boundaries.
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD_LIM  = 8'hF8;

  // Scalar value limits.
  localparam logic [20:0] MIN_LEN2   = 21'h00080;
  localparam logic [20:0] MIN_LEN3   = 21'h00800;
  localparam logic [20:0] MIN_LEN4   = 21'h10000;
  localparam logic [20:0] SURR_LO    = 21'h0D800;
  localparam logic [20:0] SURR_HI    = 21'h0DFFF;
  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;

  // Sequence lengths held in the state.
  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Payload of one input beat.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_beat_t;

  // Payload of one result beat.
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  status;
    logic        end_of_string;
  } out_beat_t;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  owed;
    logic [2:0]  seq_len;
  } dec_state_t;

endpackage

// ===== hw/rtl/utf8_chan_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps

interface utf8_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/utf8_decoder_validator.sv =====
// UTF-8 decoder and validator: top level with input and result registers.
// Each result is decoded from the input register and held in the result register.
// Throughput: one byte per cycle while the result register is free, set by the
// combinational decode step that closes the loop through the decoder state register.
// Reset (synchronous, rst_n low) empties both stages and returns the decoder
// to waiting for a lead byte.
`timescale 1ns / 1ps

module utf8_decoder_validator (
  input  logic         clk,
  input  logic         rst_n,
  utf8_chan_if.sink    in_chan,
  utf8_chan_if.source  out_chan
);

  logic                 s1_valid_r;
  utf8_pkg::in_beat_t   s1_beat_r;
  logic                 out_valid_r;
  utf8_pkg::out_beat_t  out_beat_r;
  utf8_pkg::dec_state_t state_r;
  utf8_pkg::dec_state_t state_nxt;
  logic                 res_valid;
  utf8_pkg::out_beat_t  res;
  logic                 advance;
  logic                 s1_ready;

  // The result register frees up when empty or when its beat is taken.
  assign advance  = !out_valid_r || out_chan.ready;
  assign s1_ready = !s1_valid_r || advance;

  assign in_chan.ready    = s1_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_beat_r;

  // Decode step between the input register and the result register.
  utf8_step u_step (
    .state_cur (state_r),
    .beat_in   (s1_beat_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (s1_ready && in_chan.valid) begin
      s1_beat_r <= in_chan.payload;
    end
  end

  // Decoder state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res_valid;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
    if (advance && s1_valid_r && res_valid) begin
      out_beat_r <= res;
    end
  end

  // The owed count and the sequence length are idle together.
  a_state_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.owed == 2'd0) == (state_r.seq_len == utf8_pkg::LEN_IDLE))
    else $error("decoder state owes bytes without a sequence length");

  // A byte that ends a string always yields a result closing the string.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && s1_beat_r.last_byte |=>
      out_valid_r && out_beat_r.end_of_string)
    else $error("end of string produced no closing result");

  // A good result is a Unicode scalar value.
  a_ok_is_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_beat_r.status == utf8_pkg::ST_OK |->
      out_beat_r.code_point <= utf8_pkg::MAX_SCALAR &&
      !(out_beat_r.code_point >= utf8_pkg::SURR_LO &&
        out_beat_r.code_point <= utf8_pkg::SURR_HI))
    else $error("good status with a value that is not a scalar");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_beat_r.status != utf8_pkg::ST_OK |->
      out_beat_r.code_point == 21'd0)
    else $error("error status with a nonzero value");

endmodule

// ===== hw/rtl/utf8_step.sv =====
// Combinational decode of one byte against the current decoder state.
`timescale 1ns / 1ps

module utf8_step (
  input  utf8_pkg::dec_state_t state_cur,
  input  utf8_pkg::in_beat_t   beat_in,
  output utf8_pkg::dec_state_t state_nxt,
  output logic                 res_valid,
  output utf8_pkg::out_beat_t  res
);

  logic [7:0]  b;
  logic        last;
  logic        is_cont;
  logic [20:0] value;
  logic [1:0]  owed_dec;
  logic [2:0]  check_st;

  assign b        = beat_in.byte_value;
  assign last     = beat_in.last_byte;
  assign is_cont  = (b[7:6] == 2'b10);
  assign value    = {state_cur.partial[14:0], b[5:0]};
  assign owed_dec = state_cur.owed - 2'd1;

  // Range, surrogate and overlong checks on a completed sequence.
  always_comb begin
    check_st = utf8_pkg::ST_OK;
    priority if (state_cur.seq_len == utf8_pkg::LEN_2) begin
      if (value < utf8_pkg::MIN_LEN2) check_st = utf8_pkg::ST_OVERLONG;
    end else if (state_cur.seq_len == utf8_pkg::LEN_3) begin
      priority if (value >= utf8_pkg::SURR_LO && value <= utf8_pkg::SURR_HI) begin
        check_st = utf8_pkg::ST_SURROGATE;
      end else if (value < utf8_pkg::MIN_LEN3) begin
        check_st = utf8_pkg::ST_OVERLONG;
      end else begin
        check_st = utf8_pkg::ST_OK;
      end
    end else begin
      priority if (value > utf8_pkg::MAX_SCALAR) begin
        check_st = utf8_pkg::ST_RANGE;
      end else if (value < utf8_pkg::MIN_LEN4) begin
        check_st = utf8_pkg::ST_OVERLONG;
      end else begin
        check_st = utf8_pkg::ST_OK;
      end
    end
  end

  // Next state and result selection.
  always_comb begin
    state_nxt         = '0;
    res_valid         = 1'b0;
    res.code_point    = '0;
    res.status        = utf8_pkg::ST_OK;
    res.end_of_string = last;
    if (state_cur.owed == 2'd0) begin
      // Expecting a lead byte.
      priority if (!b[7]) begin
        res_valid      = 1'b1;
        res.code_point = {13'd0, b};
      end else if (b < utf8_pkg::LEAD2_MIN || b >= utf8_pkg::LEAD_LIM) begin
        res_valid  = 1'b1;
        res.status = utf8_pkg::ST_BAD;
      end else begin
        priority if (b < utf8_pkg::LEAD3_MIN) begin
          state_nxt.partial = {16'd0, b[4:0]};
          state_nxt.owed    = 2'd1;
          state_nxt.seq_len = utf8_pkg::LEN_2;
        end else if (b < utf8_pkg::LEAD4_MIN) begin
          state_nxt.partial = {17'd0, b[3:0]};
          state_nxt.owed    = 2'd2;
          state_nxt.seq_len = utf8_pkg::LEN_3;
        end else begin
          state_nxt.partial = {18'd0, b[2:0]};
          state_nxt.owed    = 2'd3;
          state_nxt.seq_len = utf8_pkg::LEN_4;
        end
        if (last) begin
          state_nxt  = '0;
          res_valid  = 1'b1;
          res.status = utf8_pkg::ST_TRUNC;
        end
      end
    end else if (!is_cont) begin
      // Broken sequence: drop it together with this byte.
      res_valid  = 1'b1;
      res.status = utf8_pkg::ST_BAD;
    end else if (owed_dec == 2'd0) begin
      // Sequence complete.
      res_valid      = 1'b1;
      res.status     = check_st;
      res.code_point = (check_st == utf8_pkg::ST_OK) ? value : '0;
    end else if (last) begin
      res_valid  = 1'b1;
      res.status = utf8_pkg::ST_TRUNC;
    end else begin
      state_nxt.partial = value;
      state_nxt.owed    = owed_dec;
      state_nxt.seq_len = state_cur.seq_len;
    end
  end

endmodule
